// ----- rtl/core/mmt_pkg.sv -----
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types and constants for the matrix multiply with transpose block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmt_pkg;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 4;
  localparam int OUT_W   = 32;
  localparam int ACC_W   = 64;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // transaction opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_LOAD_OUT = 2'd2,
    OP_RUN      = 2'd3
  } op_t;

  // register map, word index
  typedef enum logic [2:0] {
    REG_A_ROW_COUNT   = 3'd0,
    REG_A_COL_COUNT   = 3'd1,
    REG_B_ROW_COUNT   = 3'd2,
    REG_B_COL_COUNT   = 3'd3,
    REG_OUT_ROW_COUNT = 3'd4,
    REG_OUT_COL_COUNT = 3'd5,
    REG_TRANSPOSE     = 3'd6,
    REG_CLEAR_FIRST   = 3'd7
  } reg_idx_t;

  // run sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_WRITE,
    ST_ERROR
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/matrix_multiply_transpose.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_transpose
// Q8.8 matrix multiply-accumulate with transpose flags, Q16.16 output store.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one transaction per item:
//   load A, load B, load output element, or run. Loads give no result; an
//   index past the store depth is dropped. A run checks the shapes held in
//   the APB registers. A bad shape gives one result with shape_error and
//   is_last set, from the error state that follows the check state.
//   Otherwise every output element is computed in row-major order, written
//   back to the output store and sent on the output channel
//   (out_valid/out_stall), is_last marking the final one.
//   For each output element the A and B memories are read once per inner
//   step, then come multiply, accumulate, a drain check and write-back.
//   The single read port of each of the A and B memories limits the
//   multiply to one product per cycle. in_stall stays high for the whole run.
//   A stalled result holds in the output register and the run waits on it.
//   Reset restores the register defaults and marks the whole output store
//   as zero at once; A and B contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_transpose #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mmt_pkg::op_t                        op,
  input  logic        [mmt_pkg::IDX_W-1:0]    elem_index,
  input  logic signed [ELEM_WIDTH-1:0]        elem_value,
  input  logic signed [mmt_pkg::OUT_W-1:0]    out_value_in,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mmt_pkg::OUT_W-1:0]    result_value,
  output logic        [mmt_pkg::IDX_W-1:0]    result_index,
  output logic                                is_last,
  output logic                                shape_error,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [mmt_pkg::PADDR_W-1:0]  paddr,
  input  logic        [mmt_pkg::PDATA_W-1:0]  pwdata,
  output logic        [mmt_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  import mmt_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic dim_ok(input logic [CNT_W-1:0] d);
    return (d != '0) && (int'(d) <= MAX_DIM);
  endfunction

  // configuration registers
  logic [CNT_W-1:0] a_row_count;
  logic [CNT_W-1:0] a_col_count;
  logic [CNT_W-1:0] b_row_count;
  logic [CNT_W-1:0] b_col_count;
  logic [CNT_W-1:0] out_row_count;
  logic [CNT_W-1:0] out_col_count;
  logic [1:0]       transpose_mode;
  logic             clear_first;

  // sequencer and datapath
  state_t state, state_next;
  logic   in_acc, out_free, load_ok;
  logic   issue, wr_elem, err_emit, start;
  logic   ta, tb, shape_ok, k_last, j_last, elem_last;
  logic [CNT_W-1:0] ar, ac, br, bc;
  logic [CNT_W-1:0] i, j, k;
  logic [AW-1:0]    a_kstride, a_istride, b_kstride, b_jstride;
  logic [AW-1:0]    a_addr, b_addr, a_row_base, b_col_base, oi;
  logic [DEPTH-1:0] out_vld;
  logic             s1_v, s1_first, s2_v;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc, prod_ext, acc_sum, acc_add;
  logic signed [OUT_W-1:0] sat32;
  logic        [ELEM_WIDTH-1:0] a_rdata, b_rdata;
  logic        [OUT_W-1:0]      out_rdata;
  logic                         a_we, b_we, o_we;
  logic        [AW-1:0]         o_waddr;
  logic        [OUT_W-1:0]      o_wdata;

  // apb register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_row_count    <= CNT_W'(1);
      a_col_count    <= CNT_W'(1);
      b_row_count    <= CNT_W'(1);
      b_col_count    <= CNT_W'(1);
      out_row_count  <= CNT_W'(1);
      out_col_count  <= CNT_W'(1);
      transpose_mode <= 2'd0;
      clear_first    <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_A_ROW_COUNT:   a_row_count    <= pwdata[CNT_W-1:0];
        REG_A_COL_COUNT:   a_col_count    <= pwdata[CNT_W-1:0];
        REG_B_ROW_COUNT:   b_row_count    <= pwdata[CNT_W-1:0];
        REG_B_COL_COUNT:   b_col_count    <= pwdata[CNT_W-1:0];
        REG_OUT_ROW_COUNT: out_row_count  <= pwdata[CNT_W-1:0];
        REG_OUT_COL_COUNT: out_col_count  <= pwdata[CNT_W-1:0];
        REG_TRANSPOSE:     transpose_mode <= pwdata[1:0];
        REG_CLEAR_FIRST:   clear_first    <= pwdata[0];
      endcase
    end
  end

  // apb register reads
  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_A_ROW_COUNT:   prdata = PDATA_W'(a_row_count);
      REG_A_COL_COUNT:   prdata = PDATA_W'(a_col_count);
      REG_B_ROW_COUNT:   prdata = PDATA_W'(b_row_count);
      REG_B_COL_COUNT:   prdata = PDATA_W'(b_col_count);
      REG_OUT_ROW_COUNT: prdata = PDATA_W'(out_row_count);
      REG_OUT_COL_COUNT: prdata = PDATA_W'(out_col_count);
      REG_TRANSPOSE:     prdata = PDATA_W'(transpose_mode);
      REG_CLEAR_FIRST:   prdata = PDATA_W'(clear_first);
    endcase
  end

  // effective shapes under the transpose flags
  assign ta = transpose_mode[1];
  assign tb = transpose_mode[0];
  assign ar = ta ? a_col_count : a_row_count;
  assign ac = ta ? a_row_count : a_col_count;
  assign br = tb ? b_col_count : b_row_count;
  assign bc = tb ? b_row_count : b_col_count;

  assign shape_ok = dim_ok(a_row_count) && dim_ok(a_col_count) &&
                    dim_ok(b_row_count) && dim_ok(b_col_count) &&
                    dim_ok(out_row_count) && dim_ok(out_col_count) &&
                    (ac == br) && (out_row_count == ar) && (out_col_count == bc);

  // address steps through the row-major stores
  assign a_kstride = ta ? AW'(a_col_count) : AW'(1);
  assign a_istride = ta ? AW'(1) : AW'(a_col_count);
  assign b_kstride = tb ? AW'(1) : AW'(b_col_count);
  assign b_jstride = tb ? AW'(b_col_count) : AW'(1);

  assign k_last    = (k + CNT_W'(1)) == ac;
  assign j_last    = (j + CNT_W'(1)) == out_col_count;
  assign elem_last = j_last && ((i + CNT_W'(1)) == out_row_count);

  // handshake
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_ok  = int'(elem_index) < DEPTH;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    wr_elem    = 1'b0;
    err_emit   = 1'b0;
    start      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && op == OP_RUN) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        start      = 1'b1;
        state_next = shape_ok ? ST_ISSUE : ST_ERROR;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          wr_elem    = 1'b1;
          state_next = elem_last ? ST_IDLE : ST_ISSUE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          err_emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // loop counters and read addresses
  always_ff @(posedge clk) begin
    if (start) begin
      i          <= '0;
      j          <= '0;
      k          <= '0;
      oi         <= '0;
      a_row_base <= '0;
      b_col_base <= '0;
      a_addr     <= '0;
      b_addr     <= '0;
    end else if (issue) begin
      k      <= k + CNT_W'(1);
      a_addr <= a_addr + a_kstride;
      b_addr <= b_addr + b_kstride;
    end else if (wr_elem) begin
      k  <= '0;
      oi <= oi + AW'(1);
      if (j_last) begin
        j          <= '0;
        i          <= i + CNT_W'(1);
        a_row_base <= a_row_base + a_istride;
        a_addr     <= a_row_base + a_istride;
        b_col_base <= '0;
        b_addr     <= '0;
      end else begin
        j          <= j + CNT_W'(1);
        b_col_base <= b_col_base + b_jstride;
        b_addr     <= b_col_base + b_jstride;
        a_addr     <= a_row_base;
      end
    end
  end

  // multiply-accumulate pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= issue && (k == '0);
  end

  // saturating accumulate
  assign prod_ext = ACC_W'(prod);
  assign acc_sum  = acc + prod_ext;
  always_comb begin
    acc_add = acc_sum;
    if ((acc[ACC_W-1] == prod_ext[ACC_W-1]) && (acc_sum[ACC_W-1] != acc[ACC_W-1])) begin
      acc_add = prod_ext[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  // product register and accumulator
  always_ff @(posedge clk) begin
    if (s1_v) begin
      prod <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (s1_v && s1_first) begin
      if (clear_first || !out_vld[oi]) begin
        acc <= '0;
      end else begin
        acc <= ACC_W'($signed(out_rdata));
      end
    end else if (s2_v) begin
      acc <= acc_add;
    end
  end

  // final saturation to the output range
  always_comb begin
    if (&acc[ACC_W-1:OUT_W-1] || ~|acc[ACC_W-1:OUT_W-1]) begin
      sat32 = acc[OUT_W-1:0];
    end else begin
      sat32 = acc[ACC_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  // output store entries read as zero until written
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= '0;
    end else if (o_we) begin
      out_vld[o_waddr] <= 1'b1;
    end
  end

  // memory write ports
  assign a_we    = in_acc && (op == OP_LOAD_A) && load_ok;
  assign b_we    = in_acc && (op == OP_LOAD_B) && load_ok;
  assign o_we    = (in_acc && (op == OP_LOAD_OUT) && load_ok) || wr_elem;
  assign o_waddr = wr_elem ? oi : AW'(elem_index);
  assign o_wdata = wr_elem ? sat32 : out_value_in;

  mmt_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(elem_index)),
    .wdata (elem_value),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mmt_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (AW'(elem_index)),
    .wdata (elem_value),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  mmt_ram #(
    .WIDTH (OUT_W),
    .DEPTH (DEPTH)
  ) u_out_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (oi),
    .rdata (out_rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_elem || err_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (wr_elem) begin
      result_value <= sat32;
      result_index <= IDX_W'(oi);
      is_last      <= elem_last;
      shape_error  <= 1'b0;
    end else if (err_emit) begin
      result_value <= '0;
      result_index <= '0;
      is_last      <= 1'b1;
      shape_error  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmt_ram.sv -----
// ----------------------------------------------------------------------------
// mmt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmt_check.sv -----
// ----------------------------------------------------------------------------
// mmt_check
// Port-level checks for the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  mmt_pkg::op_t                      op,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [mmt_pkg::OUT_W-1:0]  result_value,
  input  logic        [mmt_pkg::IDX_W-1:0]  result_index,
  input  logic                              is_last,
  input  logic                              shape_error
);

  import mmt_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) &&
      $stable(result_index) && $stable(is_last) && $stable(shape_error))
    else $error("stalled result changed");

  // error transaction is the single, zeroed last result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_error |-> is_last && result_value == '0 && result_index == '0)
    else $error("malformed shape error result");

  // a run closes the input channel on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_RUN |=> in_stall)
    else $error("input open right after run");

  // reset empties the output register
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply_transpose mmt_check u_mmt_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .op           (op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .result_index (result_index),
  .is_last      (is_last),
  .shape_error  (shape_error)
);

`default_nettype wire
